// File: hdl/ile_pkg.sv
// Indexed list engine: shared package.
// Holds list sizing, opcode and status codes, and the structs passed between modules.
// No dependencies.
package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int OPCODE_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_OUT_W = 9;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_PREPEND      = 3'd1,
    OP_INSERT       = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_REMOVE_FIRST = 3'd4,
    OP_REMOVE_LAST  = 3'd5,
    OP_GET          = 3'd6,
    OP_SIZE         = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]    count;
    status_t                   status;
  } result_t;

endpackage

// File: hdl/ile_cmd_if.sv
// Indexed list engine: command channel interface.
// Carries valid, ready and the command payload; depends on ile_pkg.
interface ile_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [ile_pkg::OPCODE_W-1:0]       opcode;
  logic [ile_pkg::POS_W-1:0]          position;
  logic signed [ile_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

// File: hdl/ile_rsp_if.sv
// Indexed list engine: response channel interface.
// Carries valid, ready and the result payload; depends on ile_pkg.
interface ile_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ile_pkg::VALUE_W-1:0] read_value;
  logic [ile_pkg::COUNT_OUT_W-1:0]    count;
  logic [ile_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink (input valid, input read_value, input count, input status, output ready);
endinterface

// File: hdl/indexed_list_engine.sv
// Indexed list engine: top level.
// Joins the sequencer, the element store and the response register; depends on
// ile_pkg, ile_cmd_if, ile_rsp_if, ile_mem and ile_ctrl.
//
//   channel  dir  payload                          handshake
//   cmd      in   opcode[3] position[8] value[32]  valid/ready
//   rsp      out  read_value[32] count[9] status[2] valid/ready
//
// One command at a time: size, failed commands and remove last need no store access, append
// writes the value, get reads the store and captures the data, and prepend, insert, remove at
// and remove first read and write each moved element (prepend and insert then put the value).
// The shared index counter and the single store write port set the shift cost.
// Reset empties the list; store contents are not cleared.
// A held response does not block the next command until a second result is ready.
module indexed_list_engine (
  input  logic     clk,
  input  logic     rst,
  ile_cmd_if.sink  cmd,
  ile_rsp_if.source rsp
);

  ile_pkg::mem_req_t           mem_req;
  logic [ile_pkg::VALUE_W-1:0] mem_rd_data;
  logic                        res_valid;
  logic                        res_ready;
  ile_pkg::result_t            res;
  ile_pkg::result_t            slot;
  logic                        slot_full;

  ile_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  ile_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  assign res_ready      = !slot_full || rsp.ready;
  assign rsp.valid      = slot_full;
  assign rsp.read_value = slot.read_value;
  assign rsp.count      = slot.count;
  assign rsp.status     = slot.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= 1'b0;
    end else if (res_valid && res_ready) begin
      slot_full <= 1'b1;
    end else if (rsp.ready) begin
      slot_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      slot <= res;
    end
  end

  a_slot_load: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> slot_full)
    else $error("result transaction lost");

  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    slot_full && !rsp.ready |=> slot_full && $stable(slot))
    else $error("held response changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    slot_full && !rsp.ready |-> !res_ready)
    else $error("response register overwritten");

endmodule

// File: hdl/ile_mem.sv
// Indexed list engine: element store.
// One write port and one read port with registered read data; depends on ile_pkg.
module ile_mem (
  input  logic                            clk,
  input  ile_pkg::mem_req_t               req,
  output logic [ile_pkg::VALUE_W-1:0]     rd_data
);

  logic [ile_pkg::VALUE_W-1:0] store [ile_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[req.wr_addr] <= req.wr_data;
    end
    rd_data <= store[req.rd_addr];
  end

endmodule

// File: hdl/ile_ctrl.sv
// Indexed list engine: command sequencer.
// Decodes a command, walks the shared index counter over the store to open or close
// a gap, and produces one result; depends on ile_pkg, ile_cmd_if.
module ile_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  ile_cmd_if.sink                     cmd,
  output ile_pkg::mem_req_t           mem_req,
  input  logic [ile_pkg::VALUE_W-1:0] mem_rd_data,
  output logic                        res_valid,
  output ile_pkg::result_t            res,
  input  logic                        res_ready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHR_RD,
    S_SHR_WR,
    S_SHL_RD,
    S_SHL_WR,
    S_PUT,
    S_GET_RD,
    S_GET_CAP,
    S_DONE
  } state_t;

  state_t                            state;
  logic [ile_pkg::CNT_W-1:0]         count;
  logic [ile_pkg::CNT_W-1:0]         k;
  logic [ile_pkg::CNT_W-1:0]         at;
  logic [ile_pkg::VALUE_W-1:0]       val_r;
  logic signed [ile_pkg::VALUE_W-1:0] res_value;
  ile_pkg::status_t                  res_status;

  logic [ile_pkg::CNT_W-1:0] k_dn;
  logic [ile_pkg::CNT_W-1:0] k_up;
  logic [ile_pkg::CNT_W-1:0] k_up2;
  logic [ile_pkg::CMP_W-1:0] pos_x;
  logic [ile_pkg::CMP_W-1:0] pos_x1;
  logic [ile_pkg::CMP_W-1:0] cnt_x;
  logic                      full;
  logic                      empty;

  always_comb begin
    k_dn   = k - ile_pkg::CNT_W'(1);
    k_up   = k + ile_pkg::CNT_W'(1);
    k_up2  = k + ile_pkg::CNT_W'(2);
    pos_x  = ile_pkg::CMP_W'(cmd.position);
    pos_x1 = pos_x + ile_pkg::CMP_W'(1);
    cnt_x  = ile_pkg::CMP_W'(count);
    full   = (count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
    empty  = (count == '0);
  end

  always_comb begin
    mem_req.wr_en   = (state == S_SHR_WR) || (state == S_SHL_WR) || (state == S_PUT);
    mem_req.wr_addr = (state == S_PUT) ? at[ile_pkg::ADDR_W-1:0] : k[ile_pkg::ADDR_W-1:0];
    mem_req.wr_data = (state == S_PUT) ? val_r : mem_rd_data;
    case (state)
      S_SHR_RD: mem_req.rd_addr = k_dn[ile_pkg::ADDR_W-1:0];
      S_SHL_RD: mem_req.rd_addr = k_up[ile_pkg::ADDR_W-1:0];
      default:  mem_req.rd_addr = k[ile_pkg::ADDR_W-1:0];
    endcase
  end

  assign cmd.ready      = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.read_value = res_value;
  assign res.count      = ile_pkg::COUNT_OUT_W'(count);
  assign res.status     = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      k          <= '0;
      at         <= '0;
      val_r      <= '0;
      res_value  <= '0;
      res_status <= ile_pkg::ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            val_r      <= cmd.value;
            res_value  <= '0;
            res_status <= ile_pkg::ST_OK;
            unique case (ile_pkg::op_t'(cmd.opcode))
              ile_pkg::OP_APPEND: begin
                if (full) begin
                  res_status <= ile_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  at    <= count;
                  state <= S_PUT;
                end
              end
              ile_pkg::OP_PREPEND: begin
                if (full) begin
                  res_status <= ile_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  at    <= '0;
                  k     <= count;
                  state <= empty ? S_PUT : S_SHR_RD;
                end
              end
              ile_pkg::OP_INSERT: begin
                if (full) begin
                  res_status <= ile_pkg::ST_FULL;
                  state      <= S_DONE;
                end else if (pos_x > cnt_x) begin
                  res_status <= ile_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  at    <= ile_pkg::CNT_W'(cmd.position);
                  k     <= count;
                  state <= (pos_x < cnt_x) ? S_SHR_RD : S_PUT;
                end
              end
              ile_pkg::OP_REMOVE_AT: begin
                if (pos_x >= cnt_x) begin
                  res_status <= ile_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else if (pos_x1 < cnt_x) begin
                  k     <= ile_pkg::CNT_W'(cmd.position);
                  state <= S_SHL_RD;
                end else begin
                  count <= count - ile_pkg::CNT_W'(1);
                  state <= S_DONE;
                end
              end
              ile_pkg::OP_REMOVE_FIRST: begin
                if (empty) begin
                  res_status <= ile_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else if (count > ile_pkg::CNT_W'(1)) begin
                  k     <= '0;
                  state <= S_SHL_RD;
                end else begin
                  count <= count - ile_pkg::CNT_W'(1);
                  state <= S_DONE;
                end
              end
              ile_pkg::OP_REMOVE_LAST: begin
                if (empty) begin
                  res_status <= ile_pkg::ST_RANGE;
                end else begin
                  count <= count - ile_pkg::CNT_W'(1);
                end
                state <= S_DONE;
              end
              ile_pkg::OP_GET: begin
                if (pos_x >= cnt_x) begin
                  res_status <= ile_pkg::ST_RANGE;
                  res_value  <= ile_pkg::VALUE_MIN;
                  state      <= S_DONE;
                end else begin
                  k     <= ile_pkg::CNT_W'(cmd.position);
                  state <= S_GET_RD;
                end
              end
              ile_pkg::OP_SIZE: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SHR_RD: begin
          state <= S_SHR_WR;
        end
        S_SHR_WR: begin
          k     <= k_dn;
          state <= (k_dn > at) ? S_SHR_RD : S_PUT;
        end
        S_PUT: begin
          count <= count + ile_pkg::CNT_W'(1);
          state <= S_DONE;
        end
        S_SHL_RD: begin
          state <= S_SHL_WR;
        end
        S_SHL_WR: begin
          k <= k_up;
          if (k_up2 < count) begin
            state <= S_SHL_RD;
          end else begin
            count <= count - ile_pkg::CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_GET_RD: begin
          state <= S_GET_CAP;
        end
        S_GET_CAP: begin
          res_value <= mem_rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
    else $error("element count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ile_pkg::ST_FULL) |->
      count == ile_pkg::CNT_W'(ile_pkg::CAPACITY))
    else $error("full status on a list that is not full");

  a_wr_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> ile_pkg::CNT_W'(mem_req.wr_addr) <= count)
    else $error("store write beyond list end");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> $stable(count))
    else $error("count changed while result pending");

endmodule

// File: tb/indexed_list_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_list_engine: directed, back-pressure and random list commands.
// Holds its own list mirror to predict each response; depends on ile_pkg, ile_cmd_if,
// ile_rsp_if and the RTL under hdl.
module indexed_list_engine_tb;

  localparam int MAX_GAP     = 17;
  localparam int HOLD_CYCLES = 300;
  localparam logic signed [ile_pkg::VALUE_W-1:0] VALUE_MAX = ~ile_pkg::VALUE_MIN;

  logic clk;
  logic rst;

  ile_cmd_if cmd_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  logic signed [ile_pkg::VALUE_W-1:0] mirror_vals [ile_pkg::CAPACITY];
  int                                 mirror_len;
  ile_pkg::result_t                   awaited_replies [$];
  ile_pkg::result_t                   want;

  bit tx_idle;
  bit rx_idle;
  bit rx_hold_req;
  int rx_stall;
  int rx_hold_left;
  int rx_draw;

  int err_count = 0;
  int cmds_sent;
  int replies_checked = 0;
  int full_rejects;
  int range_rejects;
  int peak_len;

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ile_pkg::result_t apply_list_command(
      input ile_pkg::op_t op,
      input logic [ile_pkg::POS_W-1:0] pos,
      input logic signed [ile_pkg::VALUE_W-1:0] val);
    ile_pkg::result_t r;
    int               at;
    int               k;
    r.read_value = '0;
    r.status     = ile_pkg::ST_OK;
    case (op)
      ile_pkg::OP_APPEND, ile_pkg::OP_PREPEND, ile_pkg::OP_INSERT: begin
        at = (op == ile_pkg::OP_APPEND) ? mirror_len :
             (op == ile_pkg::OP_PREPEND) ? 0 : int'(pos);
        if (mirror_len >= ile_pkg::CAPACITY) begin
          r.status = ile_pkg::ST_FULL;
        end else if (at > mirror_len) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          for (k = mirror_len; k > at; k--) mirror_vals[k] = mirror_vals[k-1];
          mirror_vals[at] = val;
          mirror_len++;
        end
      end
      ile_pkg::OP_REMOVE_AT, ile_pkg::OP_REMOVE_FIRST, ile_pkg::OP_REMOVE_LAST: begin
        at = (op == ile_pkg::OP_REMOVE_AT) ? int'(pos) :
             (op == ile_pkg::OP_REMOVE_FIRST) ? 0 : mirror_len - 1;
        if (mirror_len == 0 || at >= mirror_len) begin
          r.status = ile_pkg::ST_RANGE;
        end else begin
          for (k = at; k + 1 < mirror_len; k++) mirror_vals[k] = mirror_vals[k+1];
          mirror_len--;
        end
      end
      ile_pkg::OP_GET: begin
        if (int'(pos) >= mirror_len) begin
          r.status     = ile_pkg::ST_RANGE;
          r.read_value = ile_pkg::VALUE_MIN;
        end else begin
          r.read_value = mirror_vals[pos];
        end
      end
      default: ;
    endcase
    r.count = ile_pkg::COUNT_OUT_W'(mirror_len);
    if (r.status == ile_pkg::ST_FULL) full_rejects++;
    if (r.status == ile_pkg::ST_RANGE) range_rejects++;
    if (mirror_len > peak_len) peak_len = mirror_len;
    return r;
  endfunction

  function automatic logic signed [ile_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ile_pkg::VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input ile_pkg::op_t op,
                              input logic [ile_pkg::POS_W-1:0] pos,
                              input logic signed [ile_pkg::VALUE_W-1:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.position <= pos;
    cmd_ch.value    <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    awaited_replies.push_back(apply_list_command(op, pos, val));
    cmds_sent++;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic send_random_command(input int grow_pct);
    ile_pkg::op_t              op;
    logic [ile_pkg::POS_W-1:0] pos;
    int                        sel;
    sel = $urandom_range(0, 99);
    if (sel < 16) op = ile_pkg::OP_GET;
    else if (sel < 20) op = ile_pkg::OP_SIZE;
    else if ($urandom_range(0, 99) < grow_pct)
      op = ile_pkg::op_t'($urandom_range(int'(ile_pkg::OP_APPEND), int'(ile_pkg::OP_INSERT)));
    else
      op = ile_pkg::op_t'($urandom_range(int'(ile_pkg::OP_REMOVE_AT),
                                         int'(ile_pkg::OP_REMOVE_LAST)));
    if ($urandom_range(0, 99) < 15) pos = ile_pkg::POS_W'($urandom_range(0, 255));
    else if (op == ile_pkg::OP_INSERT) pos = ile_pkg::POS_W'($urandom_range(0, mirror_len));
    else pos = (mirror_len == 0) ? '0 : ile_pkg::POS_W'($urandom_range(0, mirror_len - 1));
    send_command(op, pos, pick_value());
  endtask

  task automatic test_empty_list();
    send_command(ile_pkg::OP_SIZE, 0, 0);
    send_command(ile_pkg::OP_GET, 0, 0);
    send_command(ile_pkg::OP_GET, 8'hFF, 0);
    send_command(ile_pkg::OP_REMOVE_FIRST, 0, 0);
    send_command(ile_pkg::OP_REMOVE_LAST, 0, 0);
    send_command(ile_pkg::OP_REMOVE_AT, 0, 0);
    send_command(ile_pkg::OP_INSERT, 1, 1);
    wait_drained();
  endtask

  task automatic test_basic_edits();
    send_command(ile_pkg::OP_INSERT, 0, ile_pkg::VALUE_MIN);
    send_command(ile_pkg::OP_REMOVE_LAST, 0, 0);
    send_command(ile_pkg::OP_APPEND, 0, VALUE_MAX);
    send_command(ile_pkg::OP_PREPEND, 0, ile_pkg::VALUE_MIN);
    send_command(ile_pkg::OP_INSERT, 1, 32'sh5A5A_5A5A);
    send_command(ile_pkg::OP_INSERT, 3, -1);
    send_command(ile_pkg::OP_GET, 0, 0);
    send_command(ile_pkg::OP_GET, 1, 0);
    send_command(ile_pkg::OP_GET, 2, 0);
    send_command(ile_pkg::OP_GET, 3, 0);
    send_command(ile_pkg::OP_GET, 4, 0);
    send_command(ile_pkg::OP_REMOVE_AT, 1, 0);
    send_command(ile_pkg::OP_REMOVE_FIRST, 0, 0);
    send_command(ile_pkg::OP_REMOVE_AT, 5, 0);
    send_command(ile_pkg::OP_SIZE, 0, 0);
    send_command(ile_pkg::OP_REMOVE_AT, 1, 0);
    send_command(ile_pkg::OP_REMOVE_FIRST, 0, 0);
    wait_drained();
  endtask

  // hold the response side while commands keep coming, so the engine stalls its input
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
    repeat (14) send_random_command(70);
    wait_drained();
  endtask

  task automatic test_fill_to_capacity();
    ile_pkg::op_t op;
    repeat (6) begin
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle <= 1'($urandom_range(0, 1));
      while (mirror_len < ile_pkg::CAPACITY) begin
        op = ile_pkg::op_t'($urandom_range(int'(ile_pkg::OP_APPEND), int'(ile_pkg::OP_INSERT)));
        send_command(op, ile_pkg::POS_W'($urandom_range(0, mirror_len)), pick_value());
      end
      send_command(ile_pkg::OP_APPEND, 0, pick_value());
      send_command(ile_pkg::OP_PREPEND, 0, pick_value());
      send_command(ile_pkg::OP_INSERT, ile_pkg::POS_W'($urandom_range(0, 255)), pick_value());
      send_command(ile_pkg::OP_INSERT, ile_pkg::POS_W'(ile_pkg::CAPACITY + 1), pick_value());
      send_command(ile_pkg::OP_GET, ile_pkg::POS_W'(ile_pkg::CAPACITY - 1), 0);
      send_command(ile_pkg::OP_GET, ile_pkg::POS_W'(ile_pkg::CAPACITY), 0);
      send_command(ile_pkg::OP_SIZE, 0, 0);
      repeat ($urandom_range(1, ile_pkg::CAPACITY)) send_random_command(0);
      wait_drained();
    end
  endtask

  task automatic test_random_mix();
    int grow_pct [6] = '{75, 30, 60, 25, 85, 20};
    for (int ph = 0; ph < 6; ph++) begin
      tx_idle = (ph % 4) != 1;
      rx_idle <= (ph % 4) != 2 && (ph % 4) != 3;
      if (ph == 3) tx_idle = 1'b0;
      repeat (270) send_random_command(grow_pct[ph]);
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= 0;
      rx_hold_left <= 0;
    end else if (rx_hold_req) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_stall > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= rx_stall - 1;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      rx_draw = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      rsp_ch.ready <= (rx_draw == 0);
      rx_stall     <= (rx_draw > 0) ? rx_draw - 1 : 0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        $error("response transaction with nothing outstanding: read_value %0d count %0d status %0d",
               rsp_ch.read_value, rsp_ch.count, rsp_ch.status);
        err_count++;
      end else begin
        want = awaited_replies.pop_front();
        replies_checked++;
        if (rsp_ch.read_value !== want.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d", want.read_value,
                 rsp_ch.read_value);
          err_count++;
        end
        if (rsp_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, rsp_ch.count);
          err_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_ch.status);
          err_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst             <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.opcode   <= ile_pkg::OP_SIZE;
    cmd_ch.position <= '0;
    cmd_ch.value    <= '0;
    rx_hold_req     <= 1'b0;
    rx_idle         <= 1'b1;
    tx_idle         = 1'b1;
    mirror_len      = 0;
    cmds_sent       = 0;
    full_rejects    = 0;
    range_rejects   = 0;
    peak_len        = 0;
    foreach (mirror_vals[k]) mirror_vals[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_basic_edits();
    test_backpressure();
    test_fill_to_capacity();
    test_random_mix();

    cmd_ch.valid <= 1'b0;
    guard = 0;
    while (awaited_replies.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (awaited_replies.size() != 0) begin
      $error("%0d responses never arrived", awaited_replies.size());
    end
    repeat (40) @(posedge clk);

    $display("Ran %0d list commands, checked %0d responses; peak fill %0d of %0d,",
             cmds_sent, replies_checked, peak_len, ile_pkg::CAPACITY);
    $display("  %0d full rejections, %0d range or empty rejections, %0d mismatches.",
             full_rejects, range_rejects, err_count);
    if (err_count == 0 && awaited_replies.size() == 0) begin
      $display("indexed_list_engine verification clean");
    end else begin
      $display("indexed_list_engine verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("indexed_list_engine verification failed");
    $finish;
  end

endmodule
